// ===== src/assert_macros.svh =====
// Assertion macros shared by the pan-tilt tracking step RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== src/ptts_pkg.sv =====
// Package for the pan-tilt tracking step: widths, reset values, codes and types.
// No dependencies; used by every module of the block.
package ptts_pkg;

  localparam int SIZE_W     = 13;
  localparam int POS_W      = 12;
  localparam int CENTRE_W   = 12;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 8;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 14;
  localparam int ANGLE_W    = 18;
  localparam int HMAG_W     = 19;
  localparam int DIVIDEND_W = 35;
  localparam int DIVISOR_W  = 20;
  localparam int QUOT_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int MOVE_INTERVAL_MS_DEF = 100;
  localparam int DEADBAND_PERCENT_DEF = 20;

  // Command = angle * 8 / 45, rounded half away from zero
  localparam int CMD_DIVISOR = 45;
  localparam int CMD_ROUND   = 22;

  localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
  localparam logic [GAIN_W-1:0]  YAW_GAIN_RST     = 16'd3932;
  localparam logic [GAIN_W-1:0]  PITCH_GAIN_RST   = 16'd1966;
  localparam logic [LIMIT_W-1:0] YAW_MIN_RST      = 8'd90;
  localparam logic [LIMIT_W-1:0] YAW_MAX_RST      = 8'd90;
  localparam logic [LIMIT_W-1:0] PITCH_MIN_RST    = 8'd45;
  localparam logic [LIMIT_W-1:0] PITCH_MAX_RST    = 8'd45;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_MIN      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_MAX      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX    = 4'd7;

  typedef struct packed {
    logic [SIZE_W-1:0]  frame_width;
    logic [SIZE_W-1:0]  frame_height;
    logic [GAIN_W-1:0]  yaw_gain;
    logic [GAIN_W-1:0]  pitch_gain;
    logic [LIMIT_W-1:0] yaw_min_magnitude;
    logic [LIMIT_W-1:0] yaw_max;
    logic [LIMIT_W-1:0] pitch_min_magnitude;
    logic [LIMIT_W-1:0] pitch_max;
  } cfg_regs_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFS,
    S_MULT,
    S_DIV,
    S_ACC,
    S_CPREP,
    S_CMD
  } state_t;

  typedef enum logic [1:0] {
    PH_YAW,
    PH_PITCH,
    PH_PCMD,
    PH_YCMD
  } phase_t;

endpackage

// ===== src/ptts_cfg.sv =====
// Configuration register file of the pan-tilt tracking step.
// Depends on ptts_pkg for register indexes, reset values and cfg_regs_t.
module ptts_cfg
  import ptts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_width         <= FRAME_WIDTH_RST;
      regs.frame_height        <= FRAME_HEIGHT_RST;
      regs.yaw_gain            <= YAW_GAIN_RST;
      regs.pitch_gain          <= PITCH_GAIN_RST;
      regs.yaw_min_magnitude   <= YAW_MIN_RST;
      regs.yaw_max             <= YAW_MAX_RST;
      regs.pitch_min_magnitude <= PITCH_MIN_RST;
      regs.pitch_max           <= PITCH_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  regs.frame_width         <= cfg_data[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: regs.frame_height        <= cfg_data[SIZE_W-1:0];
        CFG_YAW_GAIN:     regs.yaw_gain            <= cfg_data[GAIN_W-1:0];
        CFG_PITCH_GAIN:   regs.pitch_gain          <= cfg_data[GAIN_W-1:0];
        CFG_YAW_MIN:      regs.yaw_min_magnitude   <= cfg_data[LIMIT_W-1:0];
        CFG_YAW_MAX:      regs.yaw_max             <= cfg_data[LIMIT_W-1:0];
        CFG_PITCH_MIN:    regs.pitch_min_magnitude <= cfg_data[LIMIT_W-1:0];
        CFG_PITCH_MAX:    regs.pitch_max           <= cfg_data[LIMIT_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

endmodule

// ===== src/ptts_div.sv =====
// Shared iterative divider, two quotient bits per cycle, restoring.
// Depends on ptts_pkg for widths and the request/response structs.
`include "assert_macros.svh"
module ptts_div
  import ptts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DIV_STEPS = QUOT_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [QUOT_W-1:0]    low;
  logic [QUOT_W-1:0]    quot;
  logic [DIVISOR_W-1:0] divisor;

  logic [DIVISOR_W:0]   t1, t2, r1, r2;
  logic                 ge1, ge2;

  // Two chained compare-subtract steps
  always_comb begin
    t1  = {rem, low[QUOT_W-1]};
    ge1 = t1 >= {1'b0, divisor};
    r1  = ge1 ? (t1 - {1'b0, divisor}) : t1;
    t2  = {r1[DIVISOR_W-1:0], low[QUOT_W-2]};
    ge2 = t2 >= {1'b0, divisor};
    r2  = ge2 ? (t2 - {1'b0, divisor}) : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= DIVISOR_W'(req.dividend[DIVIDEND_W-1:QUOT_W]);
      low     <= req.dividend[QUOT_W-1:0];
      divisor <= req.divisor;
    end else if (busy) begin
      rem  <= r2[DIVISOR_W-1:0];
      low  <= {low[QUOT_W-3:0], 2'b00};
      quot <= {quot[QUOT_W-3:0], ge1, ge2};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quot;

  `ASSERT_NEVER(a_start_while_busy, clk, rst, req.start && busy, "divider restarted while busy")
  `ASSERT_PROP(a_rem_below_divisor, clk, rst, (busy && (divisor != '0)) |-> (rem < divisor), "partial remainder not below divisor")
  `ASSERT_PROP(a_done_after_busy, clk, rst, done |-> $past(busy), "done without a preceding busy cycle")

endmodule

// ===== src/pan_tilt_tracking_step_core.sv =====
// Top level of the pan-tilt tracking step: sequencer and per-axis datapath.
// Depends on ptts_pkg, ptts_cfg, ptts_div and assert_macros.svh.
//
// Use:
//   Input channel (in_valid/in_ready) transfers one detection: target_found,
//   target_x, target_y and time_ms. in_ready is high only while the sequencer
//   is idle. Output channel (out_valid/out_ready) transfers pitch_command and
//   yaw_command from an output register, so the next detection may be taken
//   while a result still waits.
//   A detection that arrives within MOVE_INTERVAL_MS of the last move, or one
//   with no target, is absorbed in its accept cycle and gives no result
//   (a target-less one past the interval still records its time).
//   A moving detection passes, per axis, through an offset step, a multiply
//   step, the shared divider (8 steps of two quotient bits, then done) and
//   an accumulate step, then per command through a set-up step, the divider
//   again and a saturate step. The one shared divider serves every division.
//   Configuration (cfg_valid/cfg_ready, always ready) is to be written while idle;
//   the block does not enforce this. Reset restores register defaults, zero
//   angles and a zero move time. If the receiver stalls, the last step holds
//   until the output register is free; the block accepts nothing meanwhile.
`include "assert_macros.svh"
module pan_tilt_tracking_step_core
  import ptts_pkg::*;
#(
  parameter int MOVE_INTERVAL_MS = MOVE_INTERVAL_MS_DEF,
  parameter int DEADBAND_PERCENT = DEADBAND_PERCENT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    target_found,
  input  logic [POS_W-1:0]        target_x,
  input  logic [POS_W-1:0]        target_y,
  input  logic [TIME_W-1:0]       time_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CMD_W-1:0] pitch_command,
  output logic signed [CMD_W-1:0] yaw_command
);

  cfg_regs_t regs;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  state_t state, state_next;
  phase_t phase;

  // Control state
  logic [TIME_W-1:0]        last_move_time;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;

  // Per-item payload
  logic [POS_W-1:0]         tx, ty;
  logic [CENTRE_W-1:0]      centre;
  logic [HMAG_W-1:0]        hmag;
  logic                     neg;
  logic                     zero;
  logic signed [CMD_W-1:0]  pitch_cmd_hold;

  // Handshake decode
  logic in_xfer, moves, out_load;
  logic [TIME_W-1:0] elapsed;

  // Offset stage
  logic [POS_W-1:0]          pos_sel;
  logic [SIZE_W-1:0]         size_sel;
  logic [CENTRE_W-1:0]       c_sel;
  logic signed [POS_W+1:0]   d_raw, c_s, d_sat;
  logic [CENTRE_W-1:0]       d_mag;
  logic [HMAG_W:0]           mag_pct, band;

  // Multiply stage
  logic [GAIN_W-1:0]         gain_sel;
  logic [DIVIDEND_W-1:0]     prod;

  // Command set-up
  logic signed [ANGLE_W-1:0] angle_sel;
  logic [ANGLE_W-1:0]        angle_mag;

  // Accumulate stage
  logic signed [ANGLE_W:0]   delta, acc_sum, lo_lim, hi_lim, acc_clamped;
  logic signed [ANGLE_W-1:0] angle_cur;
  logic [LIMIT_W-1:0]        min_sel, max_sel;

  // Saturate stage
  logic [QUOT_W-1:0]         q_neg;
  logic signed [CMD_W-1:0]   cmd;

  ptts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  ptts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign elapsed  = time_ms - last_move_time;
  assign moves    = elapsed > TIME_W'(MOVE_INTERVAL_MS);

  // Offset from centre, saturated to +/- centre, deadband test
  always_comb begin
    pos_sel  = (phase == PH_YAW) ? tx : ty;
    size_sel = (phase == PH_YAW) ? regs.frame_width : regs.frame_height;
    c_sel    = size_sel[SIZE_W-1:1];
    c_s      = $signed({2'b00, c_sel});
    d_raw    = $signed({2'b00, pos_sel}) - c_s;
    if (d_raw > c_s) begin
      d_sat = c_s;
    end else if (d_raw < -c_s) begin
      d_sat = -c_s;
    end else begin
      d_sat = d_raw;
    end
    d_mag   = (d_sat < 0) ? CENTRE_W'(-d_sat) : CENTRE_W'(d_sat);
    mag_pct = (HMAG_W+1)'(d_mag) * (HMAG_W+1)'(100);
    band    = (HMAG_W+1)'(DEADBAND_PERCENT) * (HMAG_W+1)'(c_sel);
  end

  // Scaled numerator; the centre*128 term turns the floor into round-to-nearest
  always_comb begin
    gain_sel  = (phase == PH_YAW) ? regs.yaw_gain : regs.pitch_gain;
    prod      = DIVIDEND_W'(gain_sel) * DIVIDEND_W'(hmag);
    angle_sel = (phase == PH_PCMD) ? pitch_angle : yaw_angle;
    angle_mag = (angle_sel < 0) ? ANGLE_W'(-angle_sel) : ANGLE_W'(angle_sel);
  end

  always_comb begin
    div_req.start    = (state == S_MULT) || (state == S_CPREP);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state == S_MULT) begin
      div_req.dividend = prod + DIVIDEND_W'({centre, 7'd0});
      div_req.divisor  = DIVISOR_W'({centre, 8'd0});
    end else begin
      div_req.dividend = DIVIDEND_W'({angle_mag, 3'd0}) + DIVIDEND_W'(CMD_ROUND);
      div_req.divisor  = DIVISOR_W'(CMD_DIVISOR);
    end
  end

  // Angle update: add signed change, raise to lower limit, then lower to upper
  always_comb begin
    angle_cur = (phase == PH_YAW) ? yaw_angle : pitch_angle;
    min_sel   = (phase == PH_YAW) ? regs.yaw_min_magnitude : regs.pitch_min_magnitude;
    max_sel   = (phase == PH_YAW) ? regs.yaw_max : regs.pitch_max;
    if (zero) begin
      delta = '0;
    end else if (neg) begin
      delta = -$signed({3'b000, div_rsp.quotient});
    end else begin
      delta = $signed({3'b000, div_rsp.quotient});
    end
    acc_sum = (ANGLE_W+1)'(angle_cur) + delta;
    lo_lim  = -$signed({3'b000, min_sel, 8'd0});
    hi_lim  = $signed({3'b000, max_sel, 8'd0});
    acc_clamped = acc_sum;
    if (acc_clamped < lo_lim) begin
      acc_clamped = lo_lim;
    end
    if (acc_clamped > hi_lim) begin
      acc_clamped = hi_lim;
    end
  end

  // Command saturation to the 14 bit range
  always_comb begin
    q_neg = -div_rsp.quotient;
    if (neg) begin
      cmd = (div_rsp.quotient > QUOT_W'(8192)) ? $signed(CMD_W'(14'h2000))
                                               : $signed(q_neg[CMD_W-1:0]);
    end else begin
      cmd = (div_rsp.quotient > QUOT_W'(8191)) ? $signed(CMD_W'(14'h1FFF))
                                               : $signed(div_rsp.quotient[CMD_W-1:0]);
    end
  end

  assign out_load = (state == S_CMD) && (phase == PH_YCMD) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && moves && target_found) begin
          state_next = S_OFFS;
        end
      end
      S_OFFS:  state_next = S_MULT;
      S_MULT:  state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = ((phase == PH_YAW) || (phase == PH_PITCH)) ? S_ACC : S_CMD;
        end
      end
      S_ACC:   state_next = (phase == PH_YAW) ? S_OFFS : S_CPREP;
      S_CPREP: state_next = S_DIV;
      S_CMD: begin
        if (phase == PH_PCMD) begin
          state_next = S_CPREP;
        end else if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_YAW;
      last_move_time <= '0;
      yaw_angle      <= '0;
      pitch_angle    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_xfer && moves) begin
        last_move_time <= time_ms;
      end
      if (in_xfer) begin
        phase <= PH_YAW;
      end
      if (state == S_ACC) begin
        if (phase == PH_YAW) begin
          yaw_angle <= acc_clamped[ANGLE_W-1:0];
          phase     <= PH_PITCH;
        end else begin
          pitch_angle <= acc_clamped[ANGLE_W-1:0];
          phase       <= PH_PCMD;
        end
      end
      if ((state == S_CMD) && (phase == PH_PCMD)) begin
        phase <= PH_YCMD;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tx <= target_x;
      ty <= target_y;
    end
    if (state == S_OFFS) begin
      centre <= c_sel;
      hmag   <= mag_pct[HMAG_W-1:0];
      neg    <= d_sat < 0;
      zero   <= (c_sel == '0) || (mag_pct <= band);
    end
    if (state == S_CPREP) begin
      neg  <= angle_sel < 0;
      zero <= 1'b0;
    end
    if ((state == S_CMD) && (phase == PH_PCMD)) begin
      pitch_cmd_hold <= cmd;
    end
    if (out_load) begin
      pitch_command <= pitch_cmd_hold;
      yaw_command   <= cmd;
    end
  end

  `ASSERT_PROP(a_idle_div_quiet, clk, rst, in_ready |-> !div_rsp.busy, "divider busy while accepting input")
  `ASSERT_PROP(a_result_from_cmd, clk, rst, $rose(out_valid) |-> $past(state == S_CMD), "result raised outside the command step")
  `ASSERT_PROP(a_yaw_bounded, clk, rst, (yaw_angle <= 18'sd65280) && (yaw_angle >= -18'sd65280), "yaw angle beyond any clamp limit")
  `ASSERT_PROP(a_pitch_bounded, clk, rst, (pitch_angle <= 18'sd65280) && (pitch_angle >= -18'sd65280), "pitch angle beyond any clamp limit")

endmodule
